>>> sv/lckpc_pkg.sv
// Package for the LED channel kick and pattern controller.
// Holds command, pattern and status codes, sequencer types and the
// percent-to-PWM conversion. No dependencies.
package lckpc_pkg;

    // Command codes
    localparam logic [2:0] MODE_INIT     = 3'd0;
    localparam logic [2:0] MODE_SET_ONE  = 3'd1;
    localparam logic [2:0] MODE_SET_ALL  = 3'd2;
    localparam logic [2:0] MODE_PATTERN  = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;

    // Pattern codes
    localparam logic [2:0] PAT_OFF       = 3'd0;
    localparam logic [2:0] PAT_SOLID     = 3'd1;
    localparam logic [2:0] PAT_HEARTBEAT = 3'd2;
    localparam logic [2:0] PAT_FAULT     = 3'd3;
    localparam logic [2:0] PAT_ESTOP     = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOT_INIT = 2'd1;
    localparam logic [1:0] STAT_BAD_CH   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_KICK_THR  = 2'd0;
    localparam logic [1:0] CFG_KICK_DUTY = 2'd1;
    localparam logic [1:0] CFG_KICK_HOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [6:0] KICK_THR_RST  = 7'd10;
    localparam logic [6:0] KICK_DUTY_RST = 7'd50;
    localparam logic [9:0] KICK_HOLD_RST = 10'd20;

    // Duty and timing constants
    localparam logic [6:0] DUTY_MAX      = 7'd100;
    localparam logic [6:0] DUTY_HEART    = 7'd70;
    localparam logic [9:0] PHASE_WRAP    = 10'd999;
    localparam logic [9:0] HEART_ON_MS   = 10'd50;
    localparam logic [9:0] ESTOP_ON_MS   = 10'd200;
    // phase/100 as (phase*41)>>12, exact for phase below 1000
    localparam logic [5:0] DIV100_RECIP  = 6'd41;
    // pct*255/100 as (pct*1336965)>>19, exact for pct up to 100
    localparam logic [20:0] CODE_RECIP   = 21'd1336965;

    // Results per command
    localparam logic [3:0] MAX_RESULTS   = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_SET,
        OP_LOW,
        OP_SOLID,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic [1:0] status;
        logic       write_valid;
        logic [2:0] out_channel;
        logic       force_low;
        logic [7:0] pwm_code;
        logic [9:0] hold_ms;
    } t_result;

    // Clamp to 100 percent and scale to an 8-bit compare code
    function automatic logic [7:0] pct_to_code(input logic [6:0] pct);
        logic [6:0]  p;
        logic [27:0] prod;
        p    = (pct > DUTY_MAX) ? DUTY_MAX : pct;
        prod = 28'(p) * 28'(CODE_RECIP);
        return prod[26:19];
    endfunction

endpackage

>>> sv/led_channel_kick_pattern_controller.sv
// Top level of the LED channel kick and pattern controller.
// Depends on lckpc_pkg for codes, types and the PWM code conversion.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  command  | i_valid/o_ready, mode channel duty pattern | in
//  result   | o_valid/i_ready, status .. hold_ms, last   | out
//  config   | i_cfg_valid/o_cfg_ready, index, data       | in
//
// A command is accepted in the idle state, then the sequencer steps once per
// channel visited plus once per kick write, then delivers the final result;
// a status-only request goes straight to the final delivery. The channel
// sequencer and its single PWM code multiplier set these steps. A stalled
// result output holds the sequencer only when a further result is ready to
// move. Reset is synchronous and active low; configuration writes are taken
// every cycle.
module led_channel_kick_pattern_controller
    import lckpc_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command request
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_mode,
    input  logic [2:0] i_channel,
    input  logic [7:0] i_duty_pct,
    input  logic [2:0] i_pattern,
    // result request
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic       o_write_valid,
    output logic [2:0] o_out_channel,
    output logic       o_force_low,
    output logic [7:0] o_pwm_code,
    output logic [9:0] o_hold_ms,
    output logic       o_last,
    // configuration request
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Control state
    t_state          r_state, n_state;
    t_op             r_op;
    logic            r_single;
    logic [CW-1:0]   r_idx;
    logic [6:0]      r_duty;
    logic [1:0]      r_stat;
    logic [3:0]      r_cnt;
    logic            r_kick_done;
    logic            r_pend_valid;
    t_result         r_pend;
    logic            r_out_valid;
    t_result         r_out;
    logic            r_out_last;

    // Channel and global state
    logic [6:0]      r_stored [CHANNELS];
    logic [CHANNELS-1:0] r_latch;
    logic [2:0]      r_pattern;
    logic [9:0]      r_phase;
    logic            r_ready;

    // Configuration registers
    logic [6:0]      r_kick_thr;
    logic [6:0]      r_kick_duty;
    logic [9:0]      r_kick_hold;

    // Combinational signals
    logic            s_accept;
    logic            s_out_free;
    logic            d_chan;
    t_op             d_op;
    logic [1:0]      d_stat;
    logic [6:0]      d_duty;
    logic [9:0]      s_phase_next;
    logic            s_chan_last;
    logic [15:0]     s_div_prod;
    logic            s_level;
    logic [6:0]      s_cur_duty;
    logic            s_write_en;
    logic            s_kick_need;
    logic            s_advance;
    logic [6:0]      s_code_pct;
    logic [7:0]      s_code;
    t_result         s_gen;
    logic            s_gen_keep;
    logic            s_gen_push;
    logic            s_step_ok;
    logic            s_out_load;
    t_result         s_out_data;
    logic            s_out_last;
    t_result         s_stat_item;

    assign s_accept   = i_valid && o_ready;
    assign s_out_free = !r_out_valid || i_ready;

    // Decode the command at the input
    always_comb begin
        d_chan = 1'b0;
        d_op   = OP_INIT;
        d_stat = STAT_OK;
        d_duty = (i_duty_pct > 8'(DUTY_MAX)) ? DUTY_MAX : i_duty_pct[6:0];
        case (i_mode)
            MODE_INIT: begin
                if (!r_ready) begin
                    d_chan = 1'b1;
                    d_op   = OP_INIT;
                end
            end
            MODE_SET_ONE: begin
                if (!r_ready) begin
                    d_stat = STAT_NOT_INIT;
                end else if (4'(i_channel) >= 4'(CHANNELS)) begin
                    d_stat = STAT_BAD_CH;
                end else begin
                    d_chan = 1'b1;
                    d_op   = OP_SET;
                end
            end
            MODE_SET_ALL: begin
                if (!r_ready) begin
                    d_stat = STAT_NOT_INIT;
                end else begin
                    d_chan = 1'b1;
                    d_op   = OP_SET;
                end
            end
            MODE_PATTERN: begin
                if (!r_ready) begin
                    d_stat = STAT_NOT_INIT;
                end else if (i_pattern == PAT_OFF) begin
                    d_chan = 1'b1;
                    d_op   = OP_LOW;
                end else if (i_pattern == PAT_SOLID) begin
                    d_chan = 1'b1;
                    d_op   = OP_SOLID;
                end
            end
            MODE_TICK: begin
                if (!r_ready) begin
                    d_stat = STAT_NOT_INIT;
                end else if (r_pattern inside {PAT_HEARTBEAT, PAT_FAULT, PAT_ESTOP}) begin
                    d_chan = 1'b1;
                    d_op   = OP_TICK;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the millisecond phase modulo 1000
    assign s_phase_next = (r_phase == PHASE_WRAP) ? '0 : r_phase + 10'd1;

    // Pattern level for the current phase
    assign s_div_prod = 16'(r_phase) * 16'(DIV100_RECIP);
    always_comb begin
        case (r_pattern)
            PAT_HEARTBEAT: s_level = (r_phase < HEART_ON_MS);
            PAT_FAULT:     s_level = s_div_prod[12];
            PAT_ESTOP:     s_level = (r_phase < ESTOP_ON_MS);
            default:       s_level = 1'b0;
        endcase
    end

    assign s_chan_last = r_single || (r_idx == CW'(CHANNELS - 1));

    // Work out the write for the current channel step
    always_comb begin
        s_cur_duty = '0;
        s_write_en = 1'b1;
        case (r_op)
            OP_INIT:  s_cur_duty = '0;
            OP_SET: begin
                s_cur_duty = r_duty;
                s_write_en = (r_pattern == PAT_OFF) || (r_pattern == PAT_SOLID);
            end
            OP_LOW:   s_cur_duty = '0;
            OP_SOLID: s_cur_duty = r_stored[r_idx];
            OP_TICK: begin
                if (s_level) begin
                    s_cur_duty = (r_pattern == PAT_HEARTBEAT) ? DUTY_HEART : DUTY_MAX;
                end
            end
            default:  s_write_en = 1'b0;
        endcase

        s_kick_need = s_write_en && (r_op != OP_TICK) && (s_cur_duty != '0)
                      && !r_latch[r_idx] && (s_cur_duty < r_kick_thr) && !r_kick_done;
        s_advance   = !s_kick_need;

        // Shared code unit: kick duty or channel duty
        s_code_pct = s_kick_need ? r_kick_duty : s_cur_duty;
        s_code     = pct_to_code(s_code_pct);

        s_gen.status      = STAT_OK;
        s_gen.write_valid = 1'b1;
        s_gen.out_channel = 3'(r_idx);
        s_gen.force_low   = (s_cur_duty == '0) && !s_kick_need;
        s_gen.pwm_code    = s_gen.force_low ? 8'd0 : s_code;
        s_gen.hold_ms     = s_kick_need ? r_kick_hold : 10'd0;

        s_gen_keep = s_write_en && (r_cnt < MAX_RESULTS);
        s_gen_push = s_gen_keep && r_pend_valid;
        s_step_ok  = !s_gen_push || s_out_free;
    end

    // Status-only result for the final delivery
    always_comb begin
        s_stat_item             = '0;
        s_stat_item.status      = r_stat;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = d_chan ? ST_CHAN : ST_FLUSH;
                end
            end
            ST_CHAN: begin
                if (s_step_ok && s_advance && s_chan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_ready    = 1'b0;
        s_out_load = 1'b0;
        s_out_data = r_pend;
        s_out_last = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_CHAN: begin
                s_out_load = s_gen_push && s_out_free;
            end
            ST_FLUSH: begin
                s_out_load = s_out_free;
                s_out_data = r_pend_valid ? r_pend : s_stat_item;
                s_out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op         <= OP_INIT;
            r_single     <= 1'b0;
            r_idx        <= '0;
            r_stat       <= STAT_OK;
            r_cnt        <= '0;
            r_kick_done  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_latch      <= '0;
            r_pattern    <= PAT_OFF;
            r_phase      <= '0;
            r_ready      <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_stored[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                // Latch the request and prime the sequencer
                r_op         <= d_op;
                r_single     <= (i_mode == MODE_SET_ONE);
                r_idx        <= (i_mode == MODE_SET_ONE) ? i_channel[CW-1:0] : '0;
                r_duty       <= d_duty;
                r_stat       <= d_stat;
                r_cnt        <= '0;
                r_kick_done  <= 1'b0;
                r_pend_valid <= 1'b0;
                if (!r_ready) begin
                    if (i_mode == MODE_INIT) begin
                        r_ready   <= 1'b1;
                        r_pattern <= PAT_OFF;
                        r_phase   <= '0;
                    end
                end else if (i_mode == MODE_PATTERN) begin
                    r_pattern <= i_pattern;
                    r_phase   <= '0;
                end else if (i_mode == MODE_TICK) begin
                    r_phase <= s_phase_next;
                end
            end else if (r_state == ST_CHAN && s_step_ok) begin
                // Keep the new write pending, drop it past the result limit
                if (s_gen_keep) begin
                    r_pend_valid <= 1'b1;
                    r_cnt        <= r_cnt + 4'd1;
                end
                if (s_advance) begin
                    r_kick_done <= 1'b0;
                    if (r_op == OP_INIT) begin
                        r_stored[r_idx] <= '0;
                    end else if (r_op == OP_SET) begin
                        r_stored[r_idx] <= r_duty;
                    end
                    if (s_write_en) begin
                        r_latch[r_idx] <= (s_cur_duty != '0);
                    end
                    if (!s_chan_last) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end else begin
                    r_kick_done <= 1'b1;
                end
            end else if (r_state == ST_FLUSH && s_out_free) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Pending result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHAN && s_step_ok && s_gen_keep) begin
            r_pend <= s_gen;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out      <= s_out_data;
            r_out_last <= s_out_last;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick_thr  <= KICK_THR_RST;
            r_kick_duty <= KICK_DUTY_RST;
            r_kick_hold <= KICK_HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KICK_THR:  r_kick_thr  <= i_cfg_data[6:0];
                CFG_KICK_DUTY: r_kick_duty <= i_cfg_data[6:0];
                CFG_KICK_HOLD: r_kick_hold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_write_valid = r_out.write_valid;
    assign o_out_channel = r_out.out_channel;
    assign o_force_low   = r_out.force_low;
    assign o_pwm_code    = r_out.pwm_code;
    assign o_hold_ms     = r_out.hold_ms;
    assign o_last        = r_out_last;

endmodule

>>> sv/lckpc_checker.sv
// Port checker for the LED channel kick and pattern controller.
// Sees only the top level's ports; bound to the top level below. Needs lckpc_pkg.
module lckpc_checker
    import lckpc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_write_valid,
    input logic [2:0] o_out_channel,
    input logic       o_force_low,
    input logic [7:0] o_pwm_code,
    input logic [9:0] o_hold_ms,
    input logic       o_last
);

    // Hold a stalled result valid with its code, channel and last flag unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pwm_code) && $stable(o_last)
                                && $stable(o_out_channel))
        else $error("stalled result changed");

    // Drop ready once a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // A status-only result closes its request and carries no code and no hold
    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_valid |-> o_last && o_pwm_code == 8'd0 && o_hold_ms == 10'd0)
        else $error("status-only result malformed");

    // A forced low write carries no code and no hold
    a_low_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_force_low |-> o_write_valid && o_pwm_code == 8'd0
                                   && o_hold_ms == 10'd0 && o_status == STAT_OK)
        else $error("forced low write malformed");

endmodule

bind led_channel_kick_pattern_controller lckpc_checker u_lckpc_checker (.*);
